// File: rtl/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Types, codes and constants shared by the servo pulse sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

	localparam int CHANNELS_DEFAULT = 8;

	localparam int POS_W      = 16;
	localparam int CHAN_W     = 3;
	localparam int PINS_W     = 8;
	localparam int SLOT_W     = 4;
	localparam int TICK_W     = 16;
	localparam int PULSE_W    = 13;
	localparam int CLAMP_W    = 11;
	localparam int TABLE_DEPTH = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [POS_W-1:0]   POS_MAX     = 16'd1200;
	localparam logic [PULSE_W-1:0] PULSE_BASE  = 13'd2000;
	localparam logic [PULSE_W-1:0] PULSE_RESET = 13'd1000;
	localparam logic [TICK_W-1:0]  FRAME_RESET = 16'd20000;
	localparam logic [TICK_W-1:0]  CMP_RESET   = 16'hffff;

	// item function codes
	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CHANNEL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TICKS   = 1'd1;

	typedef struct packed {
		logic              func;
		logic [CHAN_W-1:0] channel;
		logic [POS_W-1:0]  position;
	} item_t;

	typedef struct packed {
		logic [PINS_W-1:0] pulse_pins;
		logic [SLOT_W-1:0] active_slot;
		logic [TICK_W-1:0] gap_ticks;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/sps_ram.sv
// ----------------------------------------------------------------------------
// sps_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/servo_pulse_sequencer_unit.sv
// ----------------------------------------------------------------------------
// servo_pulse_sequencer_unit
// Multichannel servo pulse generator driven by timer tick and position items.
// ----------------------------------------------------------------------------
// Each accepted item yields one result with the pin vector, the active slot
// and the current trailing gap. One item is processed at a time; a new item
// is taken while the previous result still waits at the output register. A
// tick goes from idle to the done state, through a load state when a match
// loads the next channel's pulse width from the pulse table memory. A write
// walks the table from first_channel to the last channel, one read per
// cycle, summing the pulse widths for the gap, then drains and forms the
// gap (no walk when first_channel >= CHANNELS). The table's reset value is
// supplied by per-entry valid bits, so no clearing pass runs after reset.
`default_nettype none

module servo_pulse_sequencer_unit #(
	parameter int CHANNELS = sps_pkg::CHANNELS_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            item_valid,
	output logic                                 item_stall,
	input  wire sps_pkg::item_t                  item,
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output sps_pkg::result_t                     result,
	input  wire logic                            cfg_we,
	input  wire logic [sps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sps_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import sps_pkg::*;

	localparam int TABLE_AW = $clog2(TABLE_DEPTH);
	localparam logic [SLOT_W-1:0] GAP_SLOT    = SLOT_W'(CHANNELS);
	localparam logic [SLOT_W-1:0] START_SLOT  = SLOT_W'(CHANNELS + 1);
	localparam logic [TABLE_AW-1:0] LAST_CHAN = TABLE_AW'(CHANNELS - 1);
	localparam logic [TICK_W-1:0] GAP_RESET   =
		TICK_W'(20000 - CHANNELS * 2000);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUM,
		S_DRAIN,
		S_GAP,
		S_LOAD,
		S_DONE
	} state_t;

	state_t state_q;

	logic [CHAN_W-1:0]      first_q;
	logic [TICK_W-1:0]      frame_q;
	logic [TICK_W-1:0]      gap_q;
	logic [TICK_W-1:0]      tick_q;
	logic [TICK_W-1:0]      cmp_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [PINS_W-1:0]      pins_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [TABLE_AW-1:0]    idx_q;
	logic [TICK_W-1:0]      acc_q;
	logic                   sum_pend_s1;
	logic                   rd_valid_s1;
	logic                   out_valid_q;
	result_t                out_q;

	logic                   accept;
	logic                   wr_en;
	logic [CLAMP_W-1:0]     pos_clamped;
	logic [PULSE_W-1:0]     wr_pulse;
	logic [TABLE_AW-1:0]    rd_addr;
	logic [PULSE_W-1:0]     rd_data;
	logic [PULSE_W-1:0]     entry;
	logic [SLOT_W-1:0]      slot_inc;
	logic [SLOT_W-1:0]      slot_next;
	logic [PINS_W-1:0]      pins_drop;
	logic                   out_free;

	assign accept     = item_valid && (state_q == S_IDLE);
	assign item_stall = (state_q != S_IDLE);
	assign out_free   = !out_valid_q || !result_stall;

	assign wr_en       = accept && (item.func == FUNC_WRITE);
	assign pos_clamped = (item.position > POS_MAX) ? CLAMP_W'(POS_MAX)
		: item.position[CLAMP_W-1:0];
	assign wr_pulse    = PULSE_W'({pos_clamped, 1'b0}) + PULSE_BASE;

	// slot after a match, wrapping past the gap back to the first channel
	assign slot_inc  = slot_q + SLOT_W'(1);
	assign slot_next = (slot_inc >= START_SLOT) ? SLOT_W'(first_q) : slot_inc;

	// pins with the current channel's pin dropped
	assign pins_drop = (slot_q < GAP_SLOT)
		? (pins_q & ~(PINS_W'(1) << slot_q[TABLE_AW-1:0])) : pins_q;

	assign rd_addr = (state_q == S_SUM) ? idx_q : slot_next[TABLE_AW-1:0];
	// entries never written read as the reset width
	assign entry   = rd_valid_s1 ? rd_data : PULSE_RESET;

	sps_ram #(
		.WIDTH(PULSE_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(item.channel),
		.wdata(wr_pulse),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			first_q     <= '0;
			frame_q     <= FRAME_RESET;
			gap_q       <= GAP_RESET;
			tick_q      <= '0;
			cmp_q       <= CMP_RESET;
			slot_q      <= START_SLOT;
			pins_q      <= '0;
			valid_q     <= '0;
			idx_q       <= '0;
			acc_q       <= '0;
			sum_pend_s1 <= 1'b0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			rd_valid_s1 <= valid_q[rd_addr];
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_FIRST_CHANNEL: first_q <= cfg_data[CHAN_W-1:0];
					CFG_FRAME_TICKS:   frame_q <= cfg_data[TICK_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.func == FUNC_WRITE) begin
							valid_q[item.channel] <= 1'b1;
							acc_q                 <= '0;
							sum_pend_s1           <= 1'b0;
							idx_q                 <= first_q;
							if ({1'b0, first_q} < GAP_SLOT) begin
								state_q <= S_SUM;
							end else begin
								state_q <= S_GAP;
							end
						end else if (tick_q == cmp_q) begin
							tick_q <= '0;
							slot_q <= slot_next;
							if (slot_next >= GAP_SLOT) begin
								pins_q  <= pins_drop;
								cmp_q   <= gap_q;
								state_q <= S_DONE;
							end else begin
								pins_q  <= pins_drop
									| (PINS_W'(1) << slot_next[TABLE_AW-1:0]);
								state_q <= S_LOAD;
							end
						end else begin
							tick_q  <= tick_q + TICK_W'(1);
							state_q <= S_DONE;
						end
					end
				end
				S_SUM: begin
					// one read issued per cycle, its data added in the next cycle
					sum_pend_s1 <= 1'b1;
					if (sum_pend_s1) begin
						acc_q <= acc_q + TICK_W'(entry);
					end
					if (idx_q == LAST_CHAN) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + TABLE_AW'(1);
					end
				end
				S_DRAIN: begin
					sum_pend_s1 <= 1'b0;
					acc_q       <= acc_q + TICK_W'(entry);
					state_q     <= S_GAP;
				end
				S_GAP: begin
					gap_q   <= (acc_q >= frame_q) ? '0 : frame_q - acc_q;
					state_q <= S_DONE;
				end
				S_LOAD: begin
					cmp_q   <= TICK_W'(entry);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_q.pulse_pins  <= pins_q;
						out_q.active_slot <= slot_q;
						out_q.gap_ticks   <= gap_q;
						state_q           <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

// File: rtl/sps_checker.sv
// ----------------------------------------------------------------------------
// sps_checker
// Port-level checks for the servo pulse sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_checker #(
	parameter int CHANNELS = sps_pkg::CHANNELS_DEFAULT
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             result_valid,
	input wire logic             result_stall,
	input wire sps_pkg::result_t result
);

	import sps_pkg::*;

	localparam logic [SLOT_W-1:0] GAP_SLOT   = SLOT_W'(CHANNELS);
	localparam logic [SLOT_W-1:0] START_SLOT = SLOT_W'(CHANNELS + 1);

	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result valid dropped while stalled");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result changed while stalled");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.active_slot <= START_SLOT)
		else $error("active slot out of range");

	// a channel slot drives exactly its own pin, other slots drive none
	a_pin_matches_slot: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.active_slot < GAP_SLOT) |->
			result.pulse_pins == (PINS_W'(1) << result.active_slot))
		else $error("pin does not match active channel");

	a_no_pin_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.active_slot >= GAP_SLOT) |->
			result.pulse_pins == '0)
		else $error("pin high outside a channel slot");

endmodule

bind servo_pulse_sequencer_unit sps_checker #(
	.CHANNELS(CHANNELS)
) u_sps_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result      (result)
);

`default_nettype wire

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for servo_pulse_sequencer_unit. Tick and position items
// go through a bursty driver, results through a monitor under random stall;
// an in-bench model of the frame sequencer predicts pins, slot and gap.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sps_pkg::*;

	localparam int CHANNELS     = CHANNELS_DEFAULT;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 24;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_stall;
	item_t                 item         = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	servo_pulse_sequencer_unit #(
		.CHANNELS(CHANNELS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// sequencer model state
	logic [PULSE_W-1:0] pulse_width [TABLE_DEPTH];
	logic [TICK_W-1:0]  trail_gap;
	logic [TICK_W-1:0]  tick_cnt;
	logic [TICK_W-1:0]  match_at;
	logic [SLOT_W-1:0]  cur_slot;
	logic [PINS_W-1:0]  pin_bits;
	logic [CHAN_W-1:0]  start_chan;
	logic [TICK_W-1:0]  frame_len;

	item_t   servo_cmds[$];
	result_t pin_snapshots[$];

	int mismatches   = 0;
	int quiet_cycles = 0;
	bit item_took    = 1'b0;
	int burst_left   = 0;
	int gap_left     = 0;
	int stall_left   = 0;
	int stall_mode   = 0;
	int mode_left    = 0;

	task automatic report(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	function automatic result_t sequence_servo(item_t cmd);
		logic [POS_W-1:0] pos;
		int               sum;
		result_t          r;
		if (cmd.func == FUNC_WRITE) begin
			pos = (cmd.position > POS_MAX) ? POS_MAX : cmd.position;
			pulse_width[cmd.channel] = PULSE_W'(int'(pos) * 2 + int'(PULSE_BASE));
			sum = 0;
			for (int i = start_chan; i < CHANNELS && i < TABLE_DEPTH; i++)
				sum += pulse_width[i];
			trail_gap = (sum >= frame_len) ? '0 : TICK_W'(int'(frame_len) - sum);
		end else if (tick_cnt == match_at) begin
			tick_cnt = '0;
			// leaving the gap or the pre-frame slot drops no pin
			if (cur_slot < CHANNELS)
				pin_bits[cur_slot[CHAN_W-1:0]] = 1'b0;
			cur_slot = cur_slot + 1'b1;
			if (cur_slot >= CHANNELS + 1)
				cur_slot = SLOT_W'(start_chan);
			if (cur_slot >= CHANNELS) begin
				match_at = trail_gap;
			end else begin
				match_at = TICK_W'(pulse_width[cur_slot[CHAN_W-1:0]]);
				pin_bits[cur_slot[CHAN_W-1:0]] = 1'b1;
			end
		end else begin
			tick_cnt = tick_cnt + 1'b1;
		end
		r.pulse_pins  = pin_bits;
		r.active_slot = cur_slot;
		r.gap_ticks   = trail_gap;
		return r;
	endfunction

	function automatic item_t servo_cmd(logic f, int ch, int pos);
		item_t c;
		c.func     = f;
		c.channel  = CHAN_W'(ch);
		c.position = POS_W'(pos);
		return c;
	endfunction

	function automatic item_t random_cmd(int write_pct);
		item_t c;
		c.func    = ($urandom_range(0, 99) < write_pct) ? FUNC_WRITE : FUNC_TICK;
		c.channel = CHAN_W'($urandom_range(0, 7));
		case ($urandom_range(0, 3))
			0: c.position = POS_W'($urandom);
			1: begin
				case ($urandom_range(0, 4))
					0: c.position = '0;
					1: c.position = POS_MAX - 1'b1;
					2: c.position = POS_MAX;
					3: c.position = POS_MAX + 1'b1;
					default: c.position = '1;
				endcase
			end
			default: c.position = POS_W'($urandom_range(0, 1300));
		endcase
		return c;
	endfunction

	// queue random items until n ticks are in, writes mixed in at write_pct
	task automatic queue_ticks(int n, int write_pct);
		item_t c;
		int    left;
		left = n;
		while (left > 0) begin
			c = random_cmd(write_pct);
			servo_cmds.push_back(c);
			if (c.func == FUNC_TICK)
				left--;
		end
	endtask

	task automatic settle();
		while (servo_cmds.size() != 0 || pin_snapshots.size() != 0 || item_valid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		@(posedge clk);
		if (idx == CFG_FIRST_CHANNEL)
			start_chan = CHAN_W'(value);
		else
			frame_len = TICK_W'(value);
	endtask

	task automatic configure(int first, int frame);
		write_reg(CFG_FIRST_CHANNEL, first);
		write_reg(CFG_FRAME_TICKS, frame);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// acceptance, prediction, checking and watchdog
	always @(posedge clk) begin
		result_t want;
		bit      got_result;
		item_took  = arst_n && item_valid && !item_stall;
		got_result = arst_n && result_valid && !result_stall;
		if (item_took)
			pin_snapshots.push_back(sequence_servo(servo_cmds.pop_front()));
		if (got_result) begin
			if (pin_snapshots.size() == 0) begin
				report($sformatf("result %h with nothing pending", result));
			end else begin
				want = pin_snapshots.pop_front();
				if (result.pulse_pins !== want.pulse_pins)
					report($sformatf("pulse_pins got %h want %h",
						result.pulse_pins, want.pulse_pins));
				if (result.active_slot !== want.active_slot)
					report($sformatf("active_slot got %0d want %0d",
						result.active_slot, want.active_slot));
				if (result.gap_ticks !== want.gap_ticks)
					report($sformatf("gap_ticks got %0d want %0d",
						result.gap_ticks, want.gap_ticks));
			end
		end
		if (item_took || got_result)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// item driver: bursts with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_took) begin
			if (gap_left > 0) begin
				item_valid <= 1'b0;
				gap_left--;
			end else if (servo_cmds.size() > 0) begin
				item_valid <= 1'b1;
				item       <= servo_cmds[0];
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 63);
					case ($urandom_range(0, 19))
						0, 1, 2: gap_left = $urandom_range(4, 20);
						3, 4, 5, 6, 7, 8, 9: gap_left = $urandom_range(1, 3);
						default: gap_left = 0;
					endcase
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result stall pattern, switching between randomly chosen stall modes
	always @(negedge clk) begin
		bit hold;
		hold = 1'b0;
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left  = $urandom_range(50, 400);
		end else begin
			mode_left--;
		end
		if (stall_left > 0) begin
			hold = 1'b1;
			stall_left--;
		end else begin
			case (stall_mode)
				1: hold = ($urandom_range(0, 3) == 0);
				2: begin
					if ($urandom_range(0, 15) == 0) begin
						stall_left = $urandom_range(1, 8);
						hold       = 1'b1;
					end
				end
				default: hold = 1'b0;
			endcase
		end
		result_stall <= hold;
	end

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++)
			pulse_width[i] = PULSE_RESET;
		trail_gap  = TICK_W'(int'(FRAME_RESET) - CHANNELS * int'(PULSE_BASE));
		tick_cnt   = '0;
		match_at   = CMP_RESET;
		cur_slot   = SLOT_W'(CHANNELS + 1);
		pin_bits   = '0;
		start_chan = '0;
		frame_len  = FRAME_RESET;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: ticks before the first frame, clamp edges, all channels
		servo_cmds.push_back(servo_cmd(FUNC_TICK, 0, 0));
		servo_cmds.push_back(servo_cmd(FUNC_TICK, 7, 16'hffff));
		servo_cmds.push_back(servo_cmd(FUNC_WRITE, 0, 0));
		servo_cmds.push_back(servo_cmd(FUNC_WRITE, 7, POS_MAX));
		servo_cmds.push_back(servo_cmd(FUNC_WRITE, 3, POS_MAX + 1));
		servo_cmds.push_back(servo_cmd(FUNC_WRITE, 5, 16'hffff));
		servo_cmds.push_back(servo_cmd(FUNC_WRITE, 1, 16'h5555));
		servo_cmds.push_back(servo_cmd(FUNC_WRITE, 2, 16'haaaa));
		servo_cmds.push_back(servo_cmd(FUNC_WRITE, 4, 600));
		servo_cmds.push_back(servo_cmd(FUNC_WRITE, 6, POS_MAX - 1));
		servo_cmds.push_back(servo_cmd(FUNC_TICK, 2, 1));
		servo_cmds.push_back(servo_cmd(FUNC_TICK, 5, 0));
		servo_cmds.push_back(servo_cmd(FUNC_TICK, 1, 16'h8000));
		settle();

		// the reset compare value holds the first frame off, ticks only count
		configure(0, FRAME_RESET);
		queue_ticks(600, 2);
		settle();

		// last channel only, short frame so the gap saturates now and then
		configure(CHANNELS - 1, 2500);
		for (int i = 0; i < CHANNELS; i++)
			servo_cmds.push_back(servo_cmd(FUNC_WRITE, i, 0));
		queue_ticks(300, 2);
		settle();

		// longest frame: gap only shows in the result, few ticks
		configure(0, 16'hffff);
		servo_cmds.push_back(servo_cmd(FUNC_WRITE, 0, 0));
		servo_cmds.push_back(servo_cmd(FUNC_WRITE, 7, 16'hffff));
		queue_ticks(8, 85);
		settle();

		// zero frame length, gap always zero
		configure(4, 0);
		servo_cmds.push_back(servo_cmd(FUNC_WRITE, 4, 0));
		queue_ticks(300, 2);
		settle();

		configure($urandom_range(1, 6), $urandom_range(0, 30000));
		servo_cmds.push_back(random_cmd(100));
		queue_ticks(240, 20);
		settle();

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
